[rtl/core/shac_pkg.sv]
`timescale 1ns / 1ps

package shac_pkg;

    // Basic word type of the hash datapath.
    typedef logic [31:0] t_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_word;   // shift an accepted message word into the window
        logic       init;        // start a block: load working variables
        logic       first;       // with init: restart chaining from initial values
        logic       round;       // run one compression round
        logic       add;         // fold working variables into the chaining value
        logic [5:0] round_idx;   // current round number
        logic [2:0] out_idx;     // digest word selected for output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic variant;           // 1 selects SHA-224
    } t_status;

    localparam int NumRounds     = 64;
    localparam int WindowDepth   = 16;
    localparam int NumChain      = 8;
    localparam logic [2:0] LastIdx256 = 3'd7;
    localparam logic [2:0] LastIdx224 = 3'd6;

    localparam t_word IV256 [NumChain] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam t_word IV224 [NumChain] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    localparam t_word ROUND_K [NumRounds] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Rotate right by a fixed amount.
    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[rtl/core/shac_ctrl.sv]
`timescale 1ns / 1ps

module shac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_first_block,
    input  logic              i_last_block,
    input  logic              i_out_stall,
    input  shac_pkg::t_status i_status,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output logic [2:0]        o_word_position,
    output logic              o_final_word,
    output shac_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_word_cnt, n_word_cnt;
    logic [5:0] r_round, n_round;
    logic [2:0] r_out_idx, n_out_idx;
    logic       r_first, n_first;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;

    logic       in_accept;
    logic       out_accept;
    logic [2:0] last_idx;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_accept = r_out_valid && !i_out_stall;
    assign last_idx   = i_status.variant ? shac_pkg::LastIdx224 : shac_pkg::LastIdx256;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_word_cnt  = r_word_cnt;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        n_first     = r_first;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_word_cnt = r_word_cnt + 4'd1;
                    if (r_word_cnt == 4'd15) begin
                        n_first = i_first_block;
                        n_last  = i_last_block;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == 6'(shac_pkg::NumRounds - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_out_idx = '0;
                if (r_last) begin
                    n_out_valid = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_accept) begin
                    if (r_out_idx == last_idx) begin
                        n_out_valid = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
                n_state     = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_word_cnt  <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_first     <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word_cnt  <= n_word_cnt;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
            r_first     <= n_first;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_word = in_accept;
        o_cmd.init      = (r_state == S_INIT);
        o_cmd.first     = r_first;
        o_cmd.round     = (r_state == S_ROUND);
        o_cmd.add       = (r_state == S_ADD);
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_out_idx;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_word_position = r_out_idx;
    assign o_final_word    = (r_out_idx == last_idx);

endmodule

[rtl/core/shac_dp.sv]
`timescale 1ns / 1ps

module shac_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic [31:0]       i_message_word,
    input  shac_pkg::t_cmd    i_cmd,
    output shac_pkg::t_status o_status,
    output logic [31:0]       o_digest_word
);

    shac_pkg::t_word r_window [shac_pkg::WindowDepth];
    shac_pkg::t_word r_chain  [shac_pkg::NumChain];
    shac_pkg::t_word r_work   [shac_pkg::NumChain];
    logic            r_variant;

    shac_pkg::t_word w_next;
    shac_pkg::t_word t1;
    shac_pkg::t_word t2;
    shac_pkg::t_word ch;
    shac_pkg::t_word maj;

    // Message expansion: the window holds W[r] .. W[r+15] with W[r] at the bottom.
    assign w_next = shac_pkg::small_sigma1(r_window[14]) + r_window[9]
                  + shac_pkg::small_sigma0(r_window[1]) + r_window[0];

    // One compression round on a..h.
    assign ch  = r_work[6] ^ (r_work[4] & (r_work[5] ^ r_work[6]));
    assign maj = (r_work[0] & r_work[1]) | (r_work[2] & (r_work[0] | r_work[1]));
    assign t1  = r_work[7] + shac_pkg::big_sigma1(r_work[4]) + ch
               + shac_pkg::ROUND_K[i_cmd.round_idx] + r_window[0];
    assign t2  = shac_pkg::big_sigma0(r_work[0]) + maj;

    // Schedule window: shifts on each loaded word and on each round.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            for (int i = 0; i < shac_pkg::WindowDepth - 1; i++) begin
                r_window[i] <= r_window[i + 1];
            end
            r_window[shac_pkg::WindowDepth - 1] <= i_message_word;
        end else if (i_cmd.round) begin
            for (int i = 0; i < shac_pkg::WindowDepth - 1; i++) begin
                r_window[i] <= r_window[i + 1];
            end
            r_window[shac_pkg::WindowDepth - 1] <= w_next;
        end
    end

    // Working variables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < shac_pkg::NumChain; i++) begin
                if (i_cmd.first) begin
                    r_work[i] <= r_variant ? shac_pkg::IV224[i] : shac_pkg::IV256[i];
                end else begin
                    r_work[i] <= r_chain[i];
                end
            end
        end else if (i_cmd.round) begin
            for (int i = 1; i < shac_pkg::NumChain; i++) begin
                r_work[i] <= r_work[i - 1];
            end
            r_work[4] <= r_work[3] + t1;
            r_work[0] <= t1 + t2;
        end
    end

    // Chaining value and variant register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= 1'b0;
            for (int i = 0; i < shac_pkg::NumChain; i++) begin
                r_chain[i] <= shac_pkg::IV256[i];
            end
        end else begin
            if (i_cfg_we) begin
                r_variant <= i_cfg_wdata;
            end
            if (i_cmd.init && i_cmd.first) begin
                for (int i = 0; i < shac_pkg::NumChain; i++) begin
                    r_chain[i] <= r_variant ? shac_pkg::IV224[i] : shac_pkg::IV256[i];
                end
            end else if (i_cmd.add) begin
                for (int i = 0; i < shac_pkg::NumChain; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end
        end
    end

    assign o_status.variant = r_variant;
    assign o_digest_word    = r_chain[i_cmd.out_idx];

endmodule

[rtl/core/sha256_block_compressor.sv]
`timescale 1ns / 1ps
// After the sixteenth word of a block is taken, the setup state, the round states and
// the add state pass before the first digest word is valid. No new message word is
// taken until the block is compressed and, after a last block, its digest has left;
// the single round unit does one round per cycle. Digest words then leave at one per
// cycle when not stalled. Reset is synchronous, active low: chaining value to the
// SHA-256 initial values, variant to 0, count to 0.

module sha256_block_compressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_message_word,
    input  logic        i_first_block,
    input  logic        i_last_block,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_position,
    output logic        o_final_word
);

    shac_pkg::t_cmd    cmd;
    shac_pkg::t_status status;

    // Sequencer.
    shac_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_first_block   (i_first_block),
        .i_last_block    (i_last_block),
        .i_out_stall     (i_out_stall),
        .i_status        (status),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .o_word_position (o_word_position),
        .o_final_word    (o_final_word),
        .o_cmd           (cmd)
    );

    // Hash datapath.
    shac_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_message_word (i_message_word),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_digest_word  (o_digest_word)
    );

endmodule

[rtl/core/shac_checker.sv]
`timescale 1ns / 1ps

module shac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_position,
    input logic        o_final_word
);

    // A stalled digest word holds its value and position.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_digest_word) && $stable(o_word_position)))
        else $error("stalled digest word changed");

    // No message word is taken while the digest is being emitted.
    a_no_input_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while digest pending");

    // Digest words come in order, without gaps.
    a_position_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_final_word) |=>
            (o_out_valid && (o_word_position == $past(o_word_position) + 3'd1)))
        else $error("digest word position did not advance");

    // The run ends right after the final word is taken.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_final_word) |=> !o_out_valid)
        else $error("digest words continue after the final one");

    // Every run starts at the most significant word.
    a_run_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_word_position == 3'd0))
        else $error("digest run does not start at word zero");

endmodule

bind sha256_block_compressor shac_checker u_shac_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_digest_word   (o_digest_word),
    .o_word_position (o_word_position),
    .o_final_word    (o_final_word)
);
